FILE: design/cbd_pkg.sv
package cbd_pkg;

  localparam int FREQ_BASE_INT = 12000;
  localparam logic [13:0] FREQ_BASE = 14'(FREQ_BASE_INT);
  localparam logic [13:0] FREQ_MIN = 14'(FREQ_BASE_INT / 255);
  localparam int DIV_BITS = 14;

  localparam logic [11:0] VERB_GET_PARAMS = 12'hF00;
  localparam logic [11:0] VERB_SET_BEEP = 12'h70A;
  localparam logic [7:0] PARAM_NODE_COUNT = 8'h04;
  localparam logic [7:0] PARAM_GROUP_CAPS = 8'h08;
  localparam logic [7:0] PARAM_WIDGET_CAPS = 8'h09;
  localparam int GROUP_BEEP_BIT = 16;
  localparam logic [3:0] WIDGET_BEEP = 4'h7;
  localparam logic [7:0] BYTE_MAX = 8'hFF;

  localparam logic [8:0] OVR_RST = 9'h1FF;
  localparam logic [7:0] TIMEOUT_RST = 8'd100;

  localparam logic CFG_OVERRIDE = 1'b0;
  localparam logic CFG_TIMEOUT = 1'b1;

  localparam logic [1:0] KIND_START = 2'd0;
  localparam logic [1:0] KIND_STOP = 2'd1;
  localparam logic [1:0] KIND_RESP = 2'd2;
  localparam logic [1:0] KIND_TICK = 2'd3;

  typedef logic [4:0] uaddr_t;

  // microprogram step addresses
  localparam uaddr_t S_IDLE = 5'd0;
  localparam uaddr_t S_START = 5'd1;
  localparam uaddr_t S_DIVWAIT = 5'd2;
  localparam uaddr_t S_LOADDIV = 5'd3;
  localparam uaddr_t S_STOP = 5'd4;
  localparam uaddr_t S_OVR = 5'd5;
  localparam uaddr_t S_OVRNODE = 5'd6;
  localparam uaddr_t S_BEEP = 5'd7;
  localparam uaddr_t S_SENDBEEP = 5'd8;
  localparam uaddr_t S_ROOT = 5'd9;
  localparam uaddr_t S_NONODE = 5'd10;
  localparam uaddr_t S_DONE = 5'd11;
  localparam uaddr_t S_LOADG = 5'd12;
  localparam uaddr_t S_PGROUP = 5'd13;
  localparam uaddr_t S_SENDGCAPS = 5'd14;
  localparam uaddr_t S_GCAPS = 5'd15;
  localparam uaddr_t S_SENDGCOUNT = 5'd16;
  localparam uaddr_t S_SKIPG = 5'd17;
  localparam uaddr_t S_LOADW = 5'd18;
  localparam uaddr_t S_PWID = 5'd19;
  localparam uaddr_t S_SENDWID = 5'd20;
  localparam uaddr_t S_WIDGET = 5'd21;
  localparam uaddr_t S_SKIPW = 5'd22;
  localparam uaddr_t S_TICK = 5'd23;
  localparam uaddr_t S_TICKCMP = 5'd24;
  localparam uaddr_t S_TICKGRP = 5'd25;
  localparam uaddr_t S_TMO = 5'd26;
  localparam uaddr_t S_SETIDLE = 5'd27;

  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_ROOT = 3'd1,
    PH_GCAPS = 3'd2,
    PH_GCOUNT = 3'd3,
    PH_WIDGET = 3'd4,
    PH_SETBEEP = 3'd5
  } phase_t;

  typedef enum logic [1:0] {
    EV_SEND = 2'd0,
    EV_DONE = 2'd1,
    EV_NONODE = 2'd2,
    EV_TIMEOUT = 2'd3
  } ev_t;

  typedef enum logic [3:0] {
    OP_NONE,
    OP_ACCEPT,
    OP_DIV_START,
    OP_LOAD_DIV,
    OP_LOAD_ZERO,
    OP_CUR_OVR,
    OP_FOUND_CUR,
    OP_LOAD_RANGE,
    OP_CUR_INC,
    OP_WAIT_INC
  } op_t;

  typedef enum logic [3:0] {
    C_NONE,
    C_ALWAYS,
    C_DISPATCH,
    C_DIV_BUSY,
    C_OVR_NEG,
    C_CUR_ZERO,
    C_CUR_GE_END,
    C_GRP_NOBEEP,
    C_WID_BEEP,
    C_WAIT_LT,
    C_PH_GCAPS
  } cond_t;

  typedef enum logic [2:0] {
    VS_ROOT,
    VS_GCAPS,
    VS_GCOUNT,
    VS_WIDGET,
    VS_SETBEEP
  } vsel_t;

  typedef struct packed {
    op_t op;
    cond_t cond;
    uaddr_t target;
    logic emit;
    ev_t ev;
    vsel_t vsel;
    logic ph_wr;
    phase_t ph;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic out_full;
    logic div_busy;
    logic ovr_neg;
    logic cur_zero;
    logic cur_ge_end;
    logic grp_nobeep;
    logic wid_beep;
    logic wait_lt;
    logic ph_gcaps;
    uaddr_t dispatch;
  } stat_t;

  function automatic logic [31:0] make_verb(input logic [8:0] nid, input logic [11:0] v,
                                            input logic [7:0] p);
    make_verb = {3'b000, nid, v, p};
  endfunction

  function automatic logic is_busy(input phase_t ph);
    is_busy = (ph == PH_ROOT) || (ph == PH_GCAPS) || (ph == PH_GCOUNT) ||
              (ph == PH_WIDGET) || (ph == PH_SETBEEP);
  endfunction

  function automatic uaddr_t dispatch_of(input logic [1:0] kind, input phase_t ph);
    uaddr_t a;
    a = S_IDLE;
    unique case (kind)
      KIND_START: a = is_busy(ph) ? S_IDLE : S_START;
      KIND_STOP: a = is_busy(ph) ? S_IDLE : S_STOP;
      KIND_RESP: begin
        unique case (ph)
          PH_ROOT: a = S_LOADG;
          PH_GCAPS: a = S_GCAPS;
          PH_GCOUNT: a = S_LOADW;
          PH_WIDGET: a = S_WIDGET;
          PH_SETBEEP: a = S_DONE;
          default: a = S_SETIDLE;
        endcase
      end
      default: a = is_busy(ph) ? S_TICK : S_SETIDLE;
    endcase
    dispatch_of = a;
  endfunction

  function automatic ctl_t ucode(input uaddr_t addr);
    ctl_t c;
    c = '{op: OP_NONE, cond: C_NONE, target: S_IDLE, emit: 1'b0, ev: EV_SEND,
          vsel: VS_ROOT, ph_wr: 1'b0, ph: PH_IDLE};
    unique case (addr)
      S_IDLE: begin
        c.op = OP_ACCEPT;
        c.cond = C_DISPATCH;
      end
      S_START: c.op = OP_DIV_START;
      S_DIVWAIT: begin
        c.cond = C_DIV_BUSY;
        c.target = S_DIVWAIT;
      end
      S_LOADDIV: begin
        c.op = OP_LOAD_DIV;
        c.cond = C_ALWAYS;
        c.target = S_OVR;
      end
      S_STOP: c.op = OP_LOAD_ZERO;
      S_OVR: begin
        c.cond = C_OVR_NEG;
        c.target = S_ROOT;
      end
      S_OVRNODE: c.op = OP_CUR_OVR;
      S_BEEP: begin
        c.cond = C_CUR_ZERO;
        c.target = S_NONODE;
      end
      S_SENDBEEP: begin
        c.op = OP_FOUND_CUR;
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.vsel = VS_SETBEEP;
        c.ph_wr = 1'b1;
        c.ph = PH_SETBEEP;
      end
      S_ROOT: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.vsel = VS_ROOT;
        c.ph_wr = 1'b1;
        c.ph = PH_ROOT;
      end
      S_NONODE: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.ev = EV_NONODE;
        c.ph_wr = 1'b1;
      end
      S_DONE: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.ev = EV_DONE;
        c.ph_wr = 1'b1;
      end
      S_LOADG: c.op = OP_LOAD_RANGE;
      S_PGROUP: begin
        c.cond = C_CUR_GE_END;
        c.target = S_NONODE;
      end
      S_SENDGCAPS: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.vsel = VS_GCAPS;
        c.ph_wr = 1'b1;
        c.ph = PH_GCAPS;
      end
      S_GCAPS: begin
        c.cond = C_GRP_NOBEEP;
        c.target = S_SKIPG;
      end
      S_SENDGCOUNT: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.vsel = VS_GCOUNT;
        c.ph_wr = 1'b1;
        c.ph = PH_GCOUNT;
      end
      S_SKIPG: begin
        c.op = OP_CUR_INC;
        c.cond = C_ALWAYS;
        c.target = S_PGROUP;
      end
      S_LOADW: c.op = OP_LOAD_RANGE;
      S_PWID: begin
        c.cond = C_CUR_GE_END;
        c.target = S_NONODE;
      end
      S_SENDWID: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.vsel = VS_WIDGET;
        c.ph_wr = 1'b1;
        c.ph = PH_WIDGET;
      end
      S_WIDGET: begin
        c.cond = C_WID_BEEP;
        c.target = S_BEEP;
      end
      S_SKIPW: begin
        c.op = OP_CUR_INC;
        c.cond = C_ALWAYS;
        c.target = S_PWID;
      end
      S_TICK: c.op = OP_WAIT_INC;
      S_TICKCMP: begin
        c.cond = C_WAIT_LT;
        c.target = S_IDLE;
      end
      S_TICKGRP: begin
        c.cond = C_PH_GCAPS;
        c.target = S_SKIPG;
      end
      S_TMO: begin
        c.cond = C_ALWAYS;
        c.emit = 1'b1;
        c.ev = EV_TIMEOUT;
        c.ph_wr = 1'b1;
      end
      S_SETIDLE: begin
        c.cond = C_ALWAYS;
        c.ph_wr = 1'b1;
      end
      default: c.cond = C_ALWAYS;
    endcase
    ucode = c;
  endfunction

endpackage

FILE: design/cbd_div.sv
module cbd_div (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [13:0] divisor,
  output logic        busy,
  output logic [7:0]  quotient
);
  import cbd_pkg::*;

  logic        busy_r, busy_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [13:0] rem_r, rem_nxt;
  logic [13:0] quo_r, quo_nxt;
  logic [13:0] dsr_r, dsr_nxt;
  logic [14:0] trial;
  logic [14:0] diff;
  logic        fits;

  // restoring division of the fixed base, one quotient bit a cycle
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt = cnt_r;
    rem_nxt = rem_r;
    quo_nxt = quo_r;
    dsr_nxt = dsr_r;
    trial = {rem_r, FREQ_BASE[cnt_r]};
    diff = trial - {1'b0, dsr_r};
    fits = (trial >= {1'b0, dsr_r});
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 4'(DIV_BITS - 1);
      rem_nxt = '0;
      quo_nxt = '0;
      dsr_nxt = divisor;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[13:0] : trial[13:0];
      quo_nxt = {quo_r[12:0], fits};
      if (cnt_r == 4'd0) begin
        busy_nxt = 1'b0;
      end else begin
        cnt_nxt = cnt_r - 4'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign busy = busy_r;
  assign quotient = quo_r[7:0];

endmodule

FILE: design/cbd_seq.sv
module cbd_seq (
  input  logic            clk,
  input  logic            rst_n,
  input  cbd_pkg::stat_t  stat,
  output cbd_pkg::ctl_t   ctl,
  output logic            go
);
  import cbd_pkg::*;

  uaddr_t step_r, step_nxt;
  logic   taken;

  assign ctl = ucode(step_r);

  // hold on an empty input at the fetch step or on a full output slot
  assign go = !((ctl.op == OP_ACCEPT) && !stat.in_valid) && !(ctl.emit && stat.out_full);

  always_comb begin
    unique case (ctl.cond)
      C_NONE: taken = 1'b0;
      C_ALWAYS: taken = 1'b1;
      C_DISPATCH: taken = 1'b1;
      C_DIV_BUSY: taken = stat.div_busy;
      C_OVR_NEG: taken = stat.ovr_neg;
      C_CUR_ZERO: taken = stat.cur_zero;
      C_CUR_GE_END: taken = stat.cur_ge_end;
      C_GRP_NOBEEP: taken = stat.grp_nobeep;
      C_WID_BEEP: taken = stat.wid_beep;
      C_WAIT_LT: taken = stat.wait_lt;
      C_PH_GCAPS: taken = stat.ph_gcaps;
      default: taken = 1'b1;
    endcase
    step_nxt = step_r;
    if (go) begin
      if (ctl.cond == C_DISPATCH) begin
        step_nxt = stat.dispatch;
      end else if (taken) begin
        step_nxt = ctl.target;
      end else begin
        step_nxt = step_r + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= S_IDLE;
    end else begin
      step_r <= step_nxt;
    end
  end

endmodule

FILE: design/cbd_dp.sv
module cbd_dp (
  input  logic           clk,
  input  logic           rst_n,
  input  cbd_pkg::ctl_t  ctl,
  input  logic           go,
  input  logic           in_valid,
  input  logic [1:0]     in_kind,
  input  logic [31:0]    in_frequency,
  input  logic [31:0]    in_response_data,
  input  logic           cfg_we,
  input  logic           cfg_index,
  input  logic [8:0]     cfg_data,
  input  logic           out_ready,
  output logic           out_valid,
  output logic [1:0]     out_event_res,
  output logic [31:0]    out_verb,
  output logic [7:0]     out_beep_node,
  output logic [7:0]     out_divider,
  output cbd_pkg::stat_t stat
);
  import cbd_pkg::*;

  logic [8:0]  ovr_r, ovr_nxt;
  logic [7:0]  tmo_r, tmo_nxt;
  phase_t      phase_r, phase_nxt;
  logic [8:0]  cur_r, cur_nxt;
  logic [8:0]  end_r, end_nxt;
  logic [7:0]  held_r, held_nxt;
  logic [7:0]  found_r, found_nxt;
  logic [7:0]  wait_r, wait_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [1:0]  out_ev_r;
  logic [31:0] out_verb_r;
  logic [7:0]  out_node_r;
  logic [7:0]  out_div_r;
  logic [31:0] freq_r;
  logic [31:0] resp_r;
  logic        div_busy;
  logic [7:0]  div_quo;
  logic [7:0]  div_val;
  logic [31:0] verb_val;
  logic        accept;

  assign accept = go && (ctl.op == OP_ACCEPT);

  cbd_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (go && (ctl.op == OP_DIV_START)),
    .divisor  (freq_r[13:0]),
    .busy     (div_busy),
    .quotient (div_quo)
  );

  always_comb begin
    priority if (freq_r == 32'd0) begin
      div_val = 8'd0;
    end else if (freq_r > {18'd0, FREQ_BASE}) begin
      div_val = 8'd1;
    end else if (freq_r < {18'd0, FREQ_MIN}) begin
      div_val = BYTE_MAX;
    end else begin
      div_val = div_quo;
    end
  end

  always_comb begin
    unique case (ctl.vsel)
      VS_ROOT: verb_val = make_verb(9'd0, VERB_GET_PARAMS, PARAM_NODE_COUNT);
      VS_GCAPS: verb_val = make_verb(cur_r, VERB_GET_PARAMS, PARAM_GROUP_CAPS);
      VS_GCOUNT: verb_val = make_verb(cur_r, VERB_GET_PARAMS, PARAM_NODE_COUNT);
      VS_WIDGET: verb_val = make_verb(cur_r, VERB_GET_PARAMS, PARAM_WIDGET_CAPS);
      VS_SETBEEP: verb_val = make_verb(cur_r, VERB_SET_BEEP, held_r);
      default: verb_val = 32'd0;
    endcase
  end

  always_comb begin
    ovr_nxt = ovr_r;
    tmo_nxt = tmo_r;
    phase_nxt = phase_r;
    cur_nxt = cur_r;
    end_nxt = end_r;
    held_nxt = held_r;
    found_nxt = found_r;
    wait_nxt = wait_r;
    out_valid_nxt = out_valid_r;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_OVERRIDE: ovr_nxt = cfg_data;
        default: tmo_nxt = cfg_data[7:0];
      endcase
    end
    if (go) begin
      unique case (ctl.op)
        OP_LOAD_DIV, OP_LOAD_ZERO: begin
          held_nxt = (ctl.op == OP_LOAD_DIV) ? div_val : 8'd0;
          found_nxt = 8'd0;
          cur_nxt = 9'd0;
          end_nxt = 9'd0;
        end
        OP_CUR_OVR: cur_nxt = {1'b0, ovr_r[7:0]};
        OP_FOUND_CUR: found_nxt = cur_r[7:0];
        OP_LOAD_RANGE: begin
          cur_nxt = {1'b0, resp_r[23:16]};
          end_nxt = {1'b0, resp_r[23:16]} + {1'b0, resp_r[7:0]};
        end
        OP_CUR_INC: cur_nxt = cur_r + 9'd1;
        OP_WAIT_INC: begin
          if (wait_r != BYTE_MAX) begin
            wait_nxt = wait_r + 8'd1;
          end
        end
        default: ;
      endcase
      if (ctl.ph_wr) begin
        phase_nxt = ctl.ph;
      end
      if (ctl.emit && (ctl.ev == EV_SEND)) begin
        wait_nxt = 8'd0;
      end
    end
    if (go && ctl.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_r <= OVR_RST;
      tmo_r <= TIMEOUT_RST;
      phase_r <= PH_IDLE;
      cur_r <= '0;
      end_r <= '0;
      held_r <= '0;
      found_r <= '0;
      wait_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      ovr_r <= ovr_nxt;
      tmo_r <= tmo_nxt;
      phase_r <= phase_nxt;
      cur_r <= cur_nxt;
      end_r <= end_nxt;
      held_r <= held_nxt;
      found_r <= found_nxt;
      wait_r <= wait_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      freq_r <= in_frequency;
      resp_r <= in_response_data;
    end
    if (go && ctl.emit) begin
      out_ev_r <= ctl.ev;
      out_verb_r <= (ctl.ev == EV_SEND) ? verb_val : 32'd0;
      out_node_r <= (ctl.ev == EV_DONE) ? found_r : 8'd0;
      out_div_r <= held_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_res = out_ev_r;
  assign out_verb = out_verb_r;
  assign out_beep_node = out_node_r;
  assign out_divider = out_div_r;

  assign stat.in_valid = in_valid;
  assign stat.out_full = out_valid_r && !out_ready;
  assign stat.div_busy = div_busy;
  assign stat.ovr_neg = ovr_r[8];
  assign stat.cur_zero = (cur_r == 9'd0);
  assign stat.cur_ge_end = (cur_r >= end_r);
  assign stat.grp_nobeep = !resp_r[GROUP_BEEP_BIT];
  assign stat.wid_beep = (resp_r[23:20] == WIDGET_BEEP);
  assign stat.wait_lt = (wait_r < tmo_r);
  assign stat.ph_gcaps = (phase_r == PH_GCAPS);
  assign stat.dispatch = dispatch_of(in_kind, phase_r);

endmodule

FILE: design/codec_beep_discovery_sequencer.sv
// Codec beep discovery sequencer.
// Input channel (in_valid/in_ready): start and stop requests, codec
// responses and microsecond ticks. Result channel (out_valid/out_ready):
// at most one result per request - a verb to send, done, no beep node or
// codec timeout. cfg_we/cfg_index/cfg_data write the override node (0)
// and the response timeout (1); the user writes them only while the
// block is idle, which the block itself does not enforce. A microprogram
// steps through one control word per cycle while it does not hold for
// input or for a full output slot. A start request first starts the
// 14-bit restoring divider (one quotient bit per cycle), waits for it
// and loads the divider; a stop request loads a zero divider instead.
// The next request is taken once the program is back at its fetch step,
// which follows the step that registers the result; a result waiting in
// the output register does not block that, but a second result stalls
// the program until out_ready.
// Reset (rst_n low, synchronous) returns the program to its fetch step,
// clears the walk state and the output valid, and restores override -1
// and timeout 100.
module codec_beep_discovery_sequencer (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_kind,
  input  logic [31:0] in_frequency,
  input  logic [31:0] in_response_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_event_res,
  output logic [31:0] out_verb,
  output logic [7:0]  out_beep_node,
  output logic [7:0]  out_divider,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [8:0]  cfg_data
);
  import cbd_pkg::*;

  ctl_t  ctl;
  stat_t stat;
  logic  go;

  cbd_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl),
    .go    (go)
  );

  cbd_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .go               (go),
    .in_valid         (in_valid),
    .in_kind          (in_kind),
    .in_frequency     (in_frequency),
    .in_response_data (in_response_data),
    .cfg_we           (cfg_we),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .out_ready        (out_ready),
    .out_valid        (out_valid),
    .out_event_res    (out_event_res),
    .out_verb         (out_verb),
    .out_beep_node    (out_beep_node),
    .out_divider      (out_divider),
    .stat             (stat)
  );

  assign in_ready = (ctl.op == OP_ACCEPT);

endmodule

FILE: design/cbd_chk.sv
module cbd_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  out_event_res,
  input logic [31:0] out_verb,
  input logic [7:0]  out_beep_node,
  input logic [7:0]  out_divider
);
  import cbd_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_event_res) &&
    $stable(out_verb) && $stable(out_beep_node) && $stable(out_divider))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_verb_only_send: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_SEND) |-> out_verb == 32'd0)
    else $error("verb on non-send result");

  a_node_only_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_event_res != EV_DONE) |-> out_beep_node == 8'd0)
    else $error("beep node on non-done result");

endmodule

bind codec_beep_discovery_sequencer cbd_chk u_cbd_chk (
  .clk           (clk),
  .rst_n         (rst_n),
  .out_valid     (out_valid),
  .out_ready     (out_ready),
  .out_event_res (out_event_res),
  .out_verb      (out_verb),
  .out_beep_node (out_beep_node),
  .out_divider   (out_divider)
);

FILE: sim/codec_beep_discovery_sequencer_tb.sv
`timescale 1ns / 1ps

module codec_beep_discovery_sequencer_tb;
  import cbd_pkg::*;

  localparam int DRAIN_CYCLES = 64;
  localparam int LIMIT = 1_000_000;
  localparam int N_PHASE = 7;

  typedef struct packed {
    ev_t         ev;
    logic [31:0] verb;
    logic [7:0]  node;
    logic [7:0]  div;
  } beep_res_t;

  // ROW_CFG rows carry the override in freq and the timeout in resp
  typedef enum {ROW_PRED, ROW_QUIET, ROW_TYPED, ROW_CFG} row_op_t;

  typedef struct {
    row_op_t     op;
    logic [1:0]  kind;
    logic [31:0] freq;
    logic [31:0] resp;
    beep_res_t   res;
  } dir_row_t;

  localparam beep_res_t NO_RES = '0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_kind = '0;
  logic [31:0] in_frequency = '0;
  logic [31:0] in_response_data = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [1:0]  out_event_res;
  logic [31:0] out_verb;
  logic [7:0]  out_beep_node;
  logic [7:0]  out_divider;
  logic        cfg_we = 1'b0;
  logic        cfg_index = 1'b0;
  logic [8:0]  cfg_data = '0;

  codec_beep_discovery_sequencer dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind),
    .in_frequency(in_frequency), .in_response_data(in_response_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_event_res(out_event_res),
    .out_verb(out_verb), .out_beep_node(out_beep_node), .out_divider(out_divider),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // sequencer shadow state
  logic [8:0] ovr_reg = OVR_RST;
  logic [7:0] tmo_reg = TIMEOUT_RST;
  phase_t     walk_phase = PH_IDLE;
  logic [8:0] walk_cursor = '0;
  logic [8:0] walk_end = '0;
  logic [7:0] held_div = '0;
  logic [7:0] found_node = '0;
  logic [7:0] tick_count = '0;

  bit        got_event;
  beep_res_t next_event;
  bit        item_live;
  beep_res_t pending_events[$];

  int send_idle = 0;
  int recv_stall = 0;
  int errors = 0;
  int cycles = 0;

  dir_row_t dir_tab [32] = '{
    '{ROW_QUIET, KIND_TICK,  32'd0,        32'd0,        NO_RES},
    '{ROW_QUIET, KIND_RESP,  32'hFFFF_FFFF, 32'hFFFF_FFFF, NO_RES},
    '{ROW_TYPED, KIND_START, 32'd0,        32'd0,        '{EV_SEND, 32'h000F_0004, 8'd0, 8'd0}},
    '{ROW_QUIET, KIND_STOP,  32'hFFFF_FFFF, 32'd0,        NO_RES},
    '{ROW_TYPED, KIND_RESP,  32'd0,        32'hA5FF_5A03, '{EV_SEND, 32'h0FFF_0008, 8'd0, 8'd0}},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'hFFFE_FFFF, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0001_0000, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h00FE_00FF, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'hFF6F_FFFF, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0070_0000, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'hFFFF_FFFF, NO_RES},
    '{ROW_TYPED, KIND_START, 32'd12001,    32'd0,        '{EV_SEND, 32'h000F_0004, 8'd0, 8'd1}},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0000_0001, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0001_0000, NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0000_0001, NO_RES},
    '{ROW_TYPED, KIND_RESP,  32'd0,        32'h0070_0000, '{EV_NONODE, 32'd0, 8'd0, 8'd1}},
    '{ROW_CFG,   KIND_TICK,  32'h1FF,      32'd1,        NO_RES},
    '{ROW_TYPED, KIND_START, 32'd46,       32'd0,        '{EV_SEND, 32'h000F_0004, 8'd0, 8'hFF}},
    '{ROW_TYPED, KIND_TICK,  32'd0,        32'd0,        '{EV_TIMEOUT, 32'd0, 8'd0, 8'hFF}},
    '{ROW_PRED,  KIND_START, 32'd12000,    32'd0,        NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0005_0002, NO_RES},
    '{ROW_PRED,  KIND_TICK,  32'd0,        32'd0,        NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'h0001_0000, NO_RES},
    '{ROW_PRED,  KIND_TICK,  32'd0,        32'd0,        NO_RES},
    '{ROW_CFG,   KIND_TICK,  32'h000,      32'd1,        NO_RES},
    '{ROW_TYPED, KIND_START, 32'd47,       32'd0,        '{EV_NONODE, 32'd0, 8'd0, 8'hFF}},
    '{ROW_CFG,   KIND_TICK,  32'h0FE,      32'd0,        NO_RES},
    '{ROW_PRED,  KIND_STOP,  32'd0,        32'd0,        NO_RES},
    '{ROW_PRED,  KIND_TICK,  32'd0,        32'd0,        NO_RES},
    '{ROW_CFG,   KIND_TICK,  32'h100,      32'd100,      NO_RES},
    '{ROW_PRED,  KIND_START, 32'hFFFF_FFFF, 32'd0,        NO_RES},
    '{ROW_PRED,  KIND_RESP,  32'd0,        32'hFFFF_FF00, NO_RES}
  };

  int unsigned phase_ovr [N_PHASE] = '{'h1FF, 'h100, 'h000, 'h1FF, 'h0FF, 0, 0};
  int unsigned phase_tmo [N_PHASE] = '{3, 1, 2, 255, 4, 0, 2};
  int          phase_len [N_PHASE] = '{150, 120, 40, 100, 40, 60, 150};
  int          idle_pct  [4] = '{0, 59, 0, 14};
  int          stall_pct [4] = '{0, 0, 59, 14};

  function automatic logic [31:0] codec_cmd(input logic [8:0] nid, input logic [11:0] v,
                                            input logic [7:0] p);
    return {3'b000, nid, v, p};
  endfunction

  function automatic logic [7:0] beep_divider(input logic [31:0] f);
    if (f == 0) return 8'd0;
    if (f > FREQ_BASE_INT) return 8'd1;
    if (f < FREQ_BASE_INT / 255) return BYTE_MAX;
    return 8'(32'(FREQ_BASE_INT) / f);
  endfunction

  task automatic emit_event(input ev_t ev, input logic [31:0] verb, input logic [7:0] node);
    got_event = 1'b1;
    next_event.ev = ev;
    next_event.verb = verb;
    next_event.node = node;
    next_event.div = held_div;
  endtask

  task automatic send_cmd(input logic [31:0] verb, input phase_t nxt);
    tick_count = '0;
    walk_phase = nxt;
    emit_event(EV_SEND, verb, 8'd0);
  endtask

  task automatic end_req(input ev_t ev);
    walk_phase = PH_IDLE;
    emit_event(ev, 32'd0, (ev == EV_DONE) ? found_node : 8'd0);
  endtask

  task automatic start_beep(input logic [8:0] nid);
    if (nid == 0) begin
      end_req(EV_NONODE);
    end else begin
      found_node = nid[7:0];
      send_cmd(codec_cmd(nid, VERB_SET_BEEP, held_div), PH_SETBEEP);
    end
  endtask

  task automatic next_group();
    if (walk_cursor < walk_end)
      send_cmd(codec_cmd(walk_cursor, VERB_GET_PARAMS, PARAM_GROUP_CAPS), PH_GCAPS);
    else
      end_req(EV_NONODE);
  endtask

  task automatic next_widget();
    if (walk_cursor < walk_end)
      send_cmd(codec_cmd(walk_cursor, VERB_GET_PARAMS, PARAM_WIDGET_CAPS), PH_WIDGET);
    else
      end_req(EV_NONODE);
  endtask

  task automatic load_span(input logic [31:0] r);
    walk_cursor = {1'b0, r[23:16]};
    walk_end = walk_cursor + {1'b0, r[7:0]};
  endtask

  task automatic beep_predict(input logic [1:0] k, input logic [31:0] f,
                              input logic [31:0] r);
    got_event = 1'b0;
    case (k)
      KIND_START, KIND_STOP: begin
        if (walk_phase == PH_IDLE) begin
          held_div = (k == KIND_START) ? beep_divider(f) : 8'd0;
          found_node = '0;
          walk_cursor = '0;
          walk_end = '0;
          if (!ovr_reg[8])
            start_beep({1'b0, ovr_reg[7:0]});
          else
            send_cmd(codec_cmd(9'd0, VERB_GET_PARAMS, PARAM_NODE_COUNT), PH_ROOT);
        end
      end
      KIND_RESP: begin
        case (walk_phase)
          PH_ROOT: begin
            load_span(r);
            next_group();
          end
          PH_GCAPS: begin
            if (r[GROUP_BEEP_BIT]) begin
              send_cmd(codec_cmd(walk_cursor, VERB_GET_PARAMS, PARAM_NODE_COUNT), PH_GCOUNT);
            end else begin
              walk_cursor++;
              next_group();
            end
          end
          PH_GCOUNT: begin
            load_span(r);
            next_widget();
          end
          PH_WIDGET: begin
            if (r[23:20] == WIDGET_BEEP) begin
              start_beep(walk_cursor);
            end else begin
              walk_cursor++;
              next_widget();
            end
          end
          PH_SETBEEP: end_req(EV_DONE);
          default: walk_phase = PH_IDLE;
        endcase
      end
      default: begin
        if (walk_phase != PH_IDLE) begin
          if (tick_count < BYTE_MAX) tick_count++;
          if (tick_count >= tmo_reg) begin
            if (walk_phase == PH_GCAPS) begin
              walk_cursor++;
              next_group();
            end else begin
              end_req(EV_TIMEOUT);
            end
          end
        end
      end
    endcase
  endtask

  task automatic push_item(input logic [1:0] k, input logic [31:0] f, input logic [31:0] r,
                           input row_op_t how, input beep_res_t typed_res);
    in_valid <= 1'b1;
    in_kind <= k;
    in_frequency <= f;
    in_response_data <= r;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    if (walk_phase == PH_IDLE)
      item_live = (k == KIND_START) || (k == KIND_STOP);
    else
      item_live = (k == KIND_RESP) || (k == KIND_TICK);
    beep_predict(k, f, r);
    if (how == ROW_TYPED)
      pending_events.push_back(typed_res);
    else if (how == ROW_PRED && got_event)
      pending_events.push_back(next_event);
    if ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle);
    end
  endtask

  task automatic settle();
    in_valid <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic set_regs(input logic [8:0] ovr, input logic [7:0] tmo);
    cfg_we <= 1'b1;
    cfg_index <= CFG_OVERRIDE;
    cfg_data <= ovr;
    @(posedge clk);
    cfg_index <= CFG_TIMEOUT;
    cfg_data <= {1'b0, tmo};
    @(posedge clk);
    cfg_we <= 1'b0;
    ovr_reg = ovr;
    tmo_reg = tmo;
  endtask

  // walk any open request to its end in a few replies
  task automatic close_walk();
    logic [31:0] r;
    while (walk_phase != PH_IDLE) begin
      case (walk_phase)
        PH_GCAPS: r = 32'h1 << GROUP_BEEP_BIT;
        PH_WIDGET: r = {8'h00, WIDGET_BEEP, 20'h0};
        default: r = 32'h0;
      endcase
      push_item(KIND_RESP, $urandom, r, ROW_PRED, NO_RES);
    end
  endtask

  function automatic logic [31:0] pick_freq();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom_range(1, 47);
      2: return $urandom_range(48, 12000);
      3: return $urandom_range(11995, 12005);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [31:0] shaped_reply(input phase_t p);
    logic [31:0] w;
    w = $urandom;
    case (p)
      PH_ROOT, PH_GCOUNT: begin
        if ($urandom_range(99) < 80)
          w[23:16] = 8'($urandom_range(0, 7));
        else
          w[23:16] = 8'($urandom_range(248, 255));
        if ($urandom_range(99) < 90)
          w[7:0] = 8'($urandom_range(0, 4));
      end
      PH_WIDGET: if ($urandom_range(99) < 40) w[23:20] = WIDGET_BEEP;
      default: ;
    endcase
    return w;
  endfunction

  task automatic flag_field(input string what, input logic [31:0] want_v,
                            input logic [31:0] got_v);
    $display("%0t: %s mismatch, expected %h, actual %h", $time, what, want_v, got_v);
    errors++;
  endtask

  always @(posedge clk) begin
    beep_res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_events.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual event %0d verb %h",
                 $time, out_event_res, out_verb);
        errors++;
      end else begin
        want = pending_events.pop_front();
        if (out_event_res !== want.ev) flag_field("event", want.ev, out_event_res);
        if (out_verb !== want.verb) flag_field("verb", want.verb, out_verb);
        if (out_beep_node !== want.node) flag_field("beep_node", want.node, out_beep_node);
        if (out_divider !== want.div) flag_field("divider", want.div, out_divider);
      end
    end
    out_ready <= ($urandom_range(99) >= recv_stall);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("codec_beep_discovery_sequencer_tb NOT OK");
      $finish;
    end
  end

  initial begin
    logic [1:0]  k;
    logic [31:0] f;
    logic [31:0] r;
    logic [8:0]  ovr;
    logic [7:0]  tmo;
    int          n;
    int          roll;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[i]) begin
      if (dir_tab[i].op == ROW_CFG) begin
        settle();
        set_regs(dir_tab[i].freq[8:0], dir_tab[i].resp[7:0]);
      end else begin
        push_item(dir_tab[i].kind, dir_tab[i].freq, dir_tab[i].resp, dir_tab[i].op,
                  dir_tab[i].res);
      end
    end

    for (int p = 0; p < N_PHASE; p++) begin
      settle();
      send_idle = idle_pct[p % 4];
      recv_stall = stall_pct[p % 4];
      ovr = 9'(phase_ovr[p]);
      tmo = 8'(phase_tmo[p]);
      if (p == 5) begin
        ovr = 9'($urandom_range(1, 254));
        tmo = 8'($urandom_range(1, 8));
      end else if (p == 6) begin
        ovr = 9'h100 | 9'($urandom_range(0, 255));
      end
      set_regs(ovr, tmo);

      // full-length budget: one root request waited out tick by tick
      if (tmo_reg == BYTE_MAX && ovr_reg[8]) begin
        push_item(KIND_START, pick_freq(), $urandom, ROW_PRED, NO_RES);
        while (walk_phase != PH_IDLE)
          push_item(KIND_TICK, $urandom, $urandom, ROW_PRED, NO_RES);
      end

      n = 0;
      while (n < phase_len[p]) begin
        roll = $urandom_range(99);
        f = $urandom;
        r = $urandom;
        if (walk_phase == PH_IDLE) begin
          if (roll < 70) begin
            k = KIND_START;
            f = pick_freq();
          end else if (roll < 88) begin
            k = KIND_STOP;
          end else if (roll < 94) begin
            k = KIND_RESP;
          end else begin
            k = KIND_TICK;
          end
        end else if (roll < 70) begin
          k = KIND_RESP;
          r = shaped_reply(walk_phase);
        end else if (roll < 85) begin
          k = KIND_TICK;
        end else if (roll < 90) begin
          k = roll[0] ? KIND_START : KIND_STOP;
        end else begin
          k = KIND_RESP;
        end
        push_item(k, f, r, ROW_PRED, NO_RES);
        if (item_live) n++;
      end
      close_walk();
    end

    settle();
    if (errors == 0)
      $display("codec_beep_discovery_sequencer_tb OK");
    else
      $display("codec_beep_discovery_sequencer_tb NOT OK");
    $finish;
  end

endmodule

FILE: filelist.f
design/cbd_pkg.sv
design/cbd_div.sv
design/cbd_seq.sv
design/cbd_dp.sv
design/codec_beep_discovery_sequencer.sv
design/cbd_chk.sv
sim/codec_beep_discovery_sequencer_tb.sv
